FILE: src/wmh_pkg.sv
// ============================================================================
// wmh_pkg
// Shared types, constants and helpers of the 128-bit wide-multiply hash.
// ============================================================================
`default_nettype none

package wmh_pkg;

	localparam int BlockBytes = 96;
	localparam int Words      = BlockBytes / 8;
	localparam int WordIdxW   = $clog2(Words);

	localparam logic [63:0] HCONST [13] = '{
		64'h5ae31e589c56e17a, 64'h96d7bb04e64f6da9, 64'h7ab1006b26f9eb64,
		64'h21233394220b8457, 64'h047cb9557c9f3b43, 64'hd24f2590c0bcee28,
		64'h33ea8f71bb6016d8, 64'hb5d2697595d0a01f, 64'h9bb30a32f00e2b4f,
		64'h4acea09317a429d1, 64'hc2b2435dfdd545c6, 64'hfda811a785572a42,
		64'he5f50676bf67137b
	};
	localparam logic [63:0] MASK_I = 64'o1555555555555555555555;
	localparam logic [63:0] MASK_J = 64'o1333333333333333333333;
	localparam logic [63:0] MASK_K = 64'o0666666666666666666666;

	localparam logic [0:0] REG_SEED_LOW  = 1'b0;
	localparam logic [0:0] REG_SEED_HIGH = 1'b1;

	typedef logic [5:0][63:0] lanes_t;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [63:0] hash_low;
		logic [63:0] hash_high;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_WRITE, ST_ABS, ST_FIN_INIT, ST_FIN_HEAD, ST_FIN_TAIL,
		ST_MIX_A, ST_MIX_B, ST_MIX_C, ST_MIX_D, ST_MUL2, ST_MIX_E, ST_MUL3, ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MUL_LANES, MUL_IJ, MUL_JK, MUL_KI, MUL_IC, MUL_JC, MUL_KC
	} mul_src_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_ACCEPT, OP_WRITE, OP_ABS_WB, OP_FIN_INIT,
		OP_MIX_A, OP_MIX_B, OP_MIX_C, OP_MIX_D, OP_MIX_E, OP_OUT
	} dp_op_t;

	typedef enum logic [1:0] {
		RD_IDLE, RD_FETCH, RD_MERGE
	} rd_ph_t;

	typedef struct packed {
		dp_op_t     op;
		logic       rd_start;
		logic       rd_tail;
		logic [6:0] rd_off;
		logic [1:0] rd_tidx;
		logic [2:0] rd_lane;
		logic       mul_start;
		mul_src_t   mul_src;
		logic [2:0] mul_a;
		logic [2:0] mul_b;
		logic [2:0] mul_dst;
		logic [2:0] round;
	} dp_cmd_t;

	typedef struct packed {
		logic       n_zero;
		logic       pc_full;
		logic       last;
		logic       rd_done;
		logic       mul_done;
		logic [2:0] fin_rounds;
		logic       out_free;
	} dp_stat_t;

	function automatic lanes_t lane_init(input logic [63:0] slo, input logic [63:0] shi);
		lanes_t l;
		l[0] = HCONST[0] ^ (slo & MASK_I);
		l[1] = HCONST[1] ^ (shi & MASK_J);
		l[2] = HCONST[2] ^ (slo & MASK_K);
		l[3] = HCONST[3] ^ (shi & MASK_I);
		l[4] = HCONST[4] ^ (slo & MASK_J);
		l[5] = HCONST[5] ^ (shi & MASK_K);
		return l;
	endfunction

endpackage

`default_nettype wire

FILE: src/wide_multiply_hash_128_top.sv
// ============================================================================
// wide_multiply_hash_128_top
// Seeded 128-bit wide-multiply hash of a byte stream.
// ============================================================================
// Usage:
//  - in channel (in_valid/in_stall/in_data): one transaction carries a
//    little-endian word with 0..8 valid bytes (counts above 8 act as 8);
//    last closes the message. The block takes one transaction at a time.
//  - out channel (out_valid/out_stall/out_data): one transaction per
//    message, hash_low and hash_high. The result sits in an output register,
//    so the next message can start while it waits to be taken.
//  - cfg port: cfg_we writes cfg_data to seed_low (index 0) or seed_high
//    (index 1). Write while idle; before the first byte of a message the
//    new seed takes effect at once, otherwise with the next message.
//  - Sequencing, over one buffer read port and one 32x32 multiplier: an
//    item's bytes are written in one chunk when they fit in one buffer
//    word and in two when they straddle two. Absorbing a full 96-byte
//    block runs 6 rounds of two reads, a multiply and a writeback, then
//    one more check. The last item runs the finalizer with r head rounds
//    of the tail, r being 0..4.
//  - Reset zeroes seed and counters and re-inits the lanes, not the buffer.
//    A stalled result holds the finalizer in its output state.
// ============================================================================
`default_nettype none

module wide_multiply_hash_128_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire wmh_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output wmh_pkg::out_item_t      out_data,
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [63:0]        cfg_data
);

	// controller to datapath commands and status
	wmh_pkg::dp_cmd_t  cmd;
	wmh_pkg::dp_stat_t stat;

	wmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	wmh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

FILE: src/wmh_mem.sv
// ============================================================================
// wmh_mem
// Pending block buffer: 64-bit words, byte-enable write, registered read.
// ============================================================================
`default_nettype none

module wmh_mem (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [wmh_pkg::WordIdxW-1:0]  waddr,
	input  wire logic [7:0]                    wbe,
	input  wire logic [63:0]                   wdata,
	input  wire logic [wmh_pkg::WordIdxW-1:0]  raddr,
	output logic [63:0]                        rdata
);

	logic [63:0] mem [wmh_pkg::Words];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int b = 0; b < 8; b++) begin
				if (wbe[b]) mem[waddr][8*b +: 8] <= wdata[8*b +: 8];
			end
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: src/wmh_mul.sv
// ============================================================================
// wmh_mul
// 64x64->128 multiplier built from one 32x32 multiplier over four passes.
// ============================================================================
`default_nettype none

module wmh_mul (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [63:0]   a,
	input  wire logic [63:0]   b,
	output logic               done,
	output logic [127:0]       prod
);

	logic [2:0]   step_q;
	logic         busy_q;
	logic [63:0]  a_q, b_q, p_q;
	logic [127:0] acc_q, addend, acc_sum;
	logic [31:0]  ma, mb;
	logic [6:0]   sh;

	always_comb begin
		case (step_q)
			3'd0: begin ma = a_q[31:0];  mb = b_q[31:0];  end
			3'd1: begin ma = a_q[31:0];  mb = b_q[63:32]; end
			3'd2: begin ma = a_q[63:32]; mb = b_q[31:0];  end
			default: begin ma = a_q[63:32]; mb = b_q[63:32]; end
		endcase
		// shift of the partial product registered on the previous pass
		case (step_q)
			3'd2, 3'd3: sh = 7'd32;
			3'd4:       sh = 7'd64;
			default:    sh = 7'd0;
		endcase
		addend  = {64'd0, p_q} << sh;
		acc_sum = acc_q + addend;
	end

	assign done = busy_q && (step_q == 3'd4);
	assign prod = acc_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 3'd0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd4) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q != 3'd4) p_q <= ma * mb;
			if (step_q != 3'd0) acc_q <= acc_sum;
		end
	end

endmodule

`default_nettype wire

FILE: src/wmh_dp.sv
// ============================================================================
// wmh_dp
// Datapath: lanes, pending buffer, unaligned reader, multiplier, mixing.
// ============================================================================
`default_nettype none

module wmh_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wmh_pkg::dp_cmd_t   cmd,
	output wmh_pkg::dp_stat_t       stat,
	input  wire wmh_pkg::in_item_t  in_data,
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output wmh_pkg::out_item_t      out_data
);

	wmh_pkg::lanes_t    lanes_q, lo_q, hi_q;
	logic [63:0]        carry_q, len_q, seed_lo_q, seed_hi_q, word_q, i_q, j_q, k_q;
	logic [6:0]         pc_q;
	logic               abs_q;
	logic [3:0]         nrem_q;
	logic               last_q;
	wmh_pkg::out_item_t out_q;
	logic               out_valid_q;
	wmh_pkg::rd_ph_t    rd_ph_q;
	logic [6:0]         rd_off_q;
	logic [2:0]         rd_lane_q;
	logic [63:0]        rd_lo_q;
	logic [2:0]         mul_dst_q;

	logic [63:0]  seed_lo_n, seed_hi_n;
	logic [3:0]   in_n;
	logic [6:0]   q_eff;
	logic [2:0]   fin_rounds;
	logic [7:0]   tail_sum;
	logic [6:0]   tail_off, start_off;
	logic [wmh_pkg::WordIdxW-1:0] rd_w1, mem_raddr;
	logic [63:0]  mem_rdata;
	logic [127:0] rd_wide;
	logic [63:0]  rd_val;
	logic [2:0]   bo;
	logic [3:0]   room, chunk;
	logic [8:0]   be_full;
	logic [7:0]   wr_be;
	logic [63:0]  wr_data;
	logic [63:0]  mul_a, mul_b;
	logic         mul_done;
	logic [127:0] mul_prod;
	logic [127:0] rot_i, rot_j;
	logic [63:0]  abs_prev;
	wmh_pkg::out_item_t hash;

	assign seed_lo_n = (cfg_we && cfg_index == wmh_pkg::REG_SEED_LOW)  ? cfg_data : seed_lo_q;
	assign seed_hi_n = (cfg_we && cfg_index == wmh_pkg::REG_SEED_HIGH) ? cfg_data : seed_hi_q;
	assign in_n = (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;

	// short unabsorbed messages are padded to 32 bytes
	assign q_eff = (abs_q || pc_q >= 7'd32) ? pc_q : 7'd32;
	always_comb begin
		if (q_eff > 7'd80)      fin_rounds = 3'd4;
		else if (q_eff > 7'd64) fin_rounds = 3'd3;
		else if (q_eff > 7'd48) fin_rounds = 3'd2;
		else if (q_eff > 7'd32) fin_rounds = 3'd1;
		else                    fin_rounds = 3'd0;
	end

	// tail offset q-32+8t, wrapped into the 96-byte ring
	assign tail_sum  = {1'b0, q_eff} + {3'b000, cmd.rd_tidx, 3'b000} + 8'd64;
	assign tail_off  = (tail_sum >= 8'(wmh_pkg::BlockBytes))
		? 7'(tail_sum - 8'(wmh_pkg::BlockBytes)) : tail_sum[6:0];
	assign start_off = cmd.rd_tail ? tail_off : cmd.rd_off;

	assign rd_w1 = (rd_off_q[6:3] == wmh_pkg::WordIdxW'(wmh_pkg::Words - 1))
		? '0 : rd_off_q[6:3] + 1'b1;
	assign mem_raddr = (rd_ph_q == wmh_pkg::RD_FETCH) ? rd_w1 : start_off[6:3];

	always_comb begin
		logic [6:0] pos;
		rd_wide = {mem_rdata, rd_lo_q} >> {rd_off_q[2:0], 3'b000};
		for (int b = 0; b < 8; b++) begin
			pos = rd_off_q + 7'(b);
			// bytes at or past the fill point read as zero before any block is absorbed
			rd_val[8*b +: 8] = (!abs_q && pos >= pc_q) ? 8'h00 : rd_wide[8*b +: 8];
		end
	end

	// write chunk: up to the next word boundary
	assign bo      = pc_q[2:0];
	assign room    = 4'd8 - {1'b0, bo};
	assign chunk   = (nrem_q < room) ? nrem_q : room;
	assign be_full = (9'd1 << chunk) - 9'd1;
	assign wr_be   = be_full[7:0] << bo;
	assign wr_data = word_q << {bo, 3'b000};

	wmh_mem u_mem (
		.clk   (clk),
		.we    (cmd.op == wmh_pkg::OP_WRITE),
		.waddr (pc_q[6:3]),
		.wbe   (wr_be),
		.wdata (wr_data),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		case (cmd.mul_src)
			wmh_pkg::MUL_IJ: begin mul_a = i_q; mul_b = j_q; end
			wmh_pkg::MUL_JK: begin mul_a = j_q; mul_b = k_q; end
			wmh_pkg::MUL_KI: begin mul_a = k_q; mul_b = i_q; end
			wmh_pkg::MUL_IC: begin mul_a = i_q; mul_b = wmh_pkg::HCONST[10]; end
			wmh_pkg::MUL_JC: begin mul_a = j_q; mul_b = wmh_pkg::HCONST[11]; end
			wmh_pkg::MUL_KC: begin mul_a = k_q; mul_b = wmh_pkg::HCONST[12]; end
			default: begin mul_a = lanes_q[cmd.mul_a]; mul_b = lanes_q[cmd.mul_b]; end
		endcase
	end

	wmh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign rot_i = {i_q, i_q} << len_q[5:0];
	assign rot_j = {j_q, j_q} >> len_q[5:0];
	assign abs_prev = (cmd.round == 3'd0) ? carry_q : lo_q[cmd.round - 3'd1];

	assign hash.hash_low  = lo_q[3] ^ hi_q[4] ^ lo_q[5];
	assign hash.hash_high = hi_q[3] ^ lo_q[4] ^ hi_q[5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_lo_q   <= '0;
			seed_hi_q   <= '0;
			lanes_q     <= wmh_pkg::lane_init(64'd0, 64'd0);
			carry_q     <= wmh_pkg::HCONST[6];
			pc_q        <= '0;
			len_q       <= '0;
			abs_q       <= 1'b0;
			nrem_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			rd_ph_q     <= wmh_pkg::RD_IDLE;
		end else begin
			seed_lo_q <= seed_lo_n;
			seed_hi_q <= seed_hi_n;
			// new seed applies at once while the message has no bytes yet
			if (cfg_we && pc_q == 7'd0 && !abs_q)
				lanes_q <= wmh_pkg::lane_init(seed_lo_n, seed_hi_n);
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			case (rd_ph_q)
				wmh_pkg::RD_IDLE:  if (cmd.rd_start) rd_ph_q <= wmh_pkg::RD_FETCH;
				wmh_pkg::RD_FETCH: rd_ph_q <= wmh_pkg::RD_MERGE;
				wmh_pkg::RD_MERGE: begin
					lanes_q[rd_lane_q] <= lanes_q[rd_lane_q] ^ rd_val;
					rd_ph_q <= wmh_pkg::RD_IDLE;
				end
				default: rd_ph_q <= wmh_pkg::RD_IDLE;
			endcase

			case (cmd.op)
				wmh_pkg::OP_ACCEPT: begin
					nrem_q <= in_n;
					last_q <= in_data.last;
				end
				wmh_pkg::OP_WRITE: begin
					pc_q   <= pc_q + 7'(chunk);
					len_q  <= len_q + 64'(chunk);
					nrem_q <= nrem_q - chunk;
				end
				wmh_pkg::OP_ABS_WB: begin
					lanes_q[cmd.round] <= abs_prev ^ hi_q[cmd.round];
					if (cmd.round == 3'd5) begin
						carry_q <= lo_q[5];
						abs_q   <= 1'b1;
						pc_q    <= '0;
					end
				end
				wmh_pkg::OP_FIN_INIT: if (abs_q) lanes_q[0] <= lanes_q[0] ^ carry_q;
				wmh_pkg::OP_OUT: begin
					out_valid_q <= 1'b1;
					lanes_q     <= wmh_pkg::lane_init(seed_lo_q, seed_hi_q);
					carry_q     <= wmh_pkg::HCONST[6];
					pc_q        <= '0;
					len_q       <= '0;
					abs_q       <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == wmh_pkg::OP_ACCEPT) word_q <= in_data.data_word;
		else if (cmd.op == wmh_pkg::OP_WRITE) word_q <= word_q >> {chunk, 3'b000};

		if (cmd.rd_start) begin
			rd_off_q  <= start_off;
			rd_lane_q <= cmd.rd_lane;
		end
		if (rd_ph_q == wmh_pkg::RD_FETCH) rd_lo_q <= mem_rdata;

		if (cmd.mul_start) mul_dst_q <= cmd.mul_dst;
		if (mul_done) begin
			lo_q[mul_dst_q] <= mul_prod[63:0];
			hi_q[mul_dst_q] <= mul_prod[127:64];
		end

		case (cmd.op)
			wmh_pkg::OP_FIN_INIT: begin
				for (int r = 0; r < 4; r++) begin
					lo_q[r] <= '0;
					hi_q[r] <= lanes_q[r+1];
				end
			end
			wmh_pkg::OP_MIX_A: begin
				i_q <= (lanes_q[0] - lanes_q[1]) ^ wmh_pkg::HCONST[7];
				j_q <= (lanes_q[2] - lanes_q[3]) ^ wmh_pkg::HCONST[8];
				k_q <= (lanes_q[4] - lanes_q[5]) ^ wmh_pkg::HCONST[9];
			end
			wmh_pkg::OP_MIX_B: begin
				i_q <= rot_i[127:64];
				j_q <= rot_j[63:0];
				k_q <= k_q - len_q;
			end
			wmh_pkg::OP_MIX_C: begin
				i_q <= i_q - (lo_q[3] ^ hi_q[3]);
				j_q <= j_q - (lo_q[5] ^ hi_q[5]);
				k_q <= k_q - (lo_q[1] ^ hi_q[1]);
			end
			wmh_pkg::OP_MIX_D: begin
				i_q <= i_q - (lo_q[4] ^ hi_q[4]);
				j_q <= j_q - (lo_q[0] ^ hi_q[0]);
				k_q <= k_q - (lo_q[2] ^ hi_q[2]);
			end
			wmh_pkg::OP_MIX_E: begin
				i_q <= lo_q[2] ^ hi_q[0];
				j_q <= lo_q[0] ^ hi_q[1];
				k_q <= lo_q[1] ^ hi_q[2];
			end
			wmh_pkg::OP_OUT: out_q <= hash;
			default: ;
		endcase
	end

	assign stat.n_zero     = (nrem_q == 4'd0);
	assign stat.pc_full    = (pc_q == 7'(wmh_pkg::BlockBytes));
	assign stat.last       = last_q;
	assign stat.rd_done    = (rd_ph_q == wmh_pkg::RD_MERGE);
	assign stat.mul_done   = mul_done;
	assign stat.fin_rounds = fin_rounds;
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: src/wmh_ctrl.sv
// ============================================================================
// wmh_ctrl
// Sequencer: packing, block absorption, finalization program.
// ============================================================================
`default_nettype none

module wmh_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire wmh_pkg::dp_stat_t  stat,
	output wmh_pkg::dp_cmd_t        cmd
);

	wmh_pkg::state_t state_q, state_d;
	logic [2:0] round_q, round_d, ph_q, ph_d, nxt_lane;
	logic       issued_q, unit_done, want_rd, want_mul;

	assign unit_done = stat.rd_done || stat.mul_done;
	assign nxt_lane  = (round_q == 3'd5) ? 3'd0 : round_q + 3'd1;

	// next state
	always_comb begin
		state_d = state_q;
		round_d = round_q;
		ph_d    = ph_q;
		case (state_q)
			wmh_pkg::ST_IDLE: if (in_valid) state_d = wmh_pkg::ST_CHECK;
			wmh_pkg::ST_CHECK: begin
				round_d = 3'd0;
				ph_d    = 3'd0;
				if (stat.n_zero) state_d = stat.last ? wmh_pkg::ST_FIN_INIT : wmh_pkg::ST_IDLE;
				else if (stat.pc_full) state_d = wmh_pkg::ST_ABS;
				else state_d = wmh_pkg::ST_WRITE;
			end
			wmh_pkg::ST_WRITE: state_d = wmh_pkg::ST_CHECK;
			wmh_pkg::ST_ABS: begin
				if (ph_q == 3'd3) begin
					ph_d = 3'd0;
					if (round_q == 3'd5) state_d = wmh_pkg::ST_CHECK;
					else round_d = round_q + 3'd1;
				end else if (unit_done) ph_d = ph_q + 3'd1;
			end
			wmh_pkg::ST_FIN_INIT: begin
				round_d = 3'd0;
				ph_d    = 3'd0;
				state_d = (stat.fin_rounds == 3'd0) ? wmh_pkg::ST_FIN_TAIL : wmh_pkg::ST_FIN_HEAD;
			end
			wmh_pkg::ST_FIN_HEAD: begin
				if (unit_done) begin
					if (ph_q == 3'd2) begin
						ph_d = 3'd0;
						if (round_q + 3'd1 == stat.fin_rounds) state_d = wmh_pkg::ST_FIN_TAIL;
						else round_d = round_q + 3'd1;
					end else ph_d = ph_q + 3'd1;
				end
			end
			wmh_pkg::ST_FIN_TAIL: begin
				if (unit_done) begin
					if (ph_q == 3'd5) begin
						ph_d = 3'd0;
						state_d = wmh_pkg::ST_MIX_A;
					end else ph_d = ph_q + 3'd1;
				end
			end
			wmh_pkg::ST_MIX_A: state_d = wmh_pkg::ST_MIX_B;
			wmh_pkg::ST_MIX_B: state_d = wmh_pkg::ST_MIX_C;
			wmh_pkg::ST_MIX_C: state_d = wmh_pkg::ST_MIX_D;
			wmh_pkg::ST_MIX_D: begin
				ph_d = 3'd0;
				state_d = wmh_pkg::ST_MUL2;
			end
			wmh_pkg::ST_MUL2: begin
				if (unit_done) begin
					if (ph_q == 3'd2) begin
						ph_d = 3'd0;
						state_d = wmh_pkg::ST_MIX_E;
					end else ph_d = ph_q + 3'd1;
				end
			end
			wmh_pkg::ST_MIX_E: begin
				ph_d = 3'd0;
				state_d = wmh_pkg::ST_MUL3;
			end
			wmh_pkg::ST_MUL3: begin
				if (unit_done) begin
					if (ph_q == 3'd2) begin
						ph_d = 3'd0;
						state_d = wmh_pkg::ST_OUT;
					end else ph_d = ph_q + 3'd1;
				end
			end
			wmh_pkg::ST_OUT: if (stat.out_free) state_d = wmh_pkg::ST_IDLE;
			default: state_d = wmh_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		cmd.op   = wmh_pkg::OP_NONE;
		cmd.mul_src = wmh_pkg::MUL_LANES;
		cmd.round = round_q;
		want_rd  = 1'b0;
		want_mul = 1'b0;
		case (state_q)
			wmh_pkg::ST_IDLE:  if (in_valid) cmd.op = wmh_pkg::OP_ACCEPT;
			wmh_pkg::ST_WRITE: cmd.op = wmh_pkg::OP_WRITE;
			wmh_pkg::ST_ABS, wmh_pkg::ST_FIN_HEAD: begin
				case (ph_q)
					3'd0: begin
						want_rd = 1'b1;
						cmd.rd_off  = {round_q, 1'b0, 3'b000};
						cmd.rd_lane = round_q;
					end
					3'd1: begin
						want_rd = 1'b1;
						cmd.rd_off  = {round_q, 1'b1, 3'b000};
						cmd.rd_lane = nxt_lane;
					end
					3'd2: begin
						want_mul = 1'b1;
						cmd.mul_a   = round_q;
						cmd.mul_b   = nxt_lane;
						cmd.mul_dst = round_q;
					end
					default: if (state_q == wmh_pkg::ST_ABS) cmd.op = wmh_pkg::OP_ABS_WB;
				endcase
			end
			wmh_pkg::ST_FIN_INIT: cmd.op = wmh_pkg::OP_FIN_INIT;
			wmh_pkg::ST_FIN_TAIL: begin
				cmd.rd_tail = 1'b1;
				case (ph_q)
					3'd0: begin want_rd = 1'b1; cmd.rd_tidx = 2'd0; cmd.rd_lane = 3'd4; end
					3'd1: begin want_rd = 1'b1; cmd.rd_tidx = 2'd1; cmd.rd_lane = 3'd5; end
					3'd2: begin
						want_mul = 1'b1; cmd.mul_a = 3'd4; cmd.mul_b = 3'd5; cmd.mul_dst = 3'd4;
					end
					3'd3: begin want_rd = 1'b1; cmd.rd_tidx = 2'd2; cmd.rd_lane = 3'd5; end
					3'd4: begin want_rd = 1'b1; cmd.rd_tidx = 2'd3; cmd.rd_lane = 3'd0; end
					default: begin
						want_mul = 1'b1; cmd.mul_a = 3'd5; cmd.mul_b = 3'd0; cmd.mul_dst = 3'd5;
					end
				endcase
			end
			wmh_pkg::ST_MIX_A: cmd.op = wmh_pkg::OP_MIX_A;
			wmh_pkg::ST_MIX_B: cmd.op = wmh_pkg::OP_MIX_B;
			wmh_pkg::ST_MIX_C: cmd.op = wmh_pkg::OP_MIX_C;
			wmh_pkg::ST_MIX_D: cmd.op = wmh_pkg::OP_MIX_D;
			wmh_pkg::ST_MIX_E: cmd.op = wmh_pkg::OP_MIX_E;
			wmh_pkg::ST_MUL2: begin
				want_mul = 1'b1;
				cmd.mul_dst = ph_q;
				case (ph_q)
					3'd0:    cmd.mul_src = wmh_pkg::MUL_IJ;
					3'd1:    cmd.mul_src = wmh_pkg::MUL_JK;
					default: cmd.mul_src = wmh_pkg::MUL_KI;
				endcase
			end
			wmh_pkg::ST_MUL3: begin
				want_mul = 1'b1;
				cmd.mul_dst = ph_q + 3'd3;
				case (ph_q)
					3'd0:    cmd.mul_src = wmh_pkg::MUL_IC;
					3'd1:    cmd.mul_src = wmh_pkg::MUL_JC;
					default: cmd.mul_src = wmh_pkg::MUL_KC;
				endcase
			end
			wmh_pkg::ST_OUT: if (stat.out_free) cmd.op = wmh_pkg::OP_OUT;
			default: ;
		endcase
		cmd.rd_start  = want_rd && !issued_q;
		cmd.mul_start = want_mul && !issued_q;
	end

	assign in_stall = (state_q != wmh_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wmh_pkg::ST_IDLE;
			round_q  <= '0;
			ph_q     <= '0;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			round_q  <= round_d;
			ph_q     <= ph_d;
			issued_q <= unit_done ? 1'b0 : (issued_q | cmd.rd_start | cmd.mul_start);
		end
	end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the 128-bit wide-multiply hash: random messages,
// seed changes between phases, and a local predictor of every hash.
// ============================================================================
`default_nettype none

module testbench;

	localparam logic [63:0] MASK_I_C = 64'o1555555555555555555555;
	localparam logic [63:0] MASK_J_C = 64'o1333333333333333333333;
	localparam logic [63:0] MASK_K_C = 64'o0666666666666666666666;
	localparam logic [63:0] KC [13] = '{
		64'h5ae31e589c56e17a, 64'h96d7bb04e64f6da9, 64'h7ab1006b26f9eb64,
		64'h21233394220b8457, 64'h047cb9557c9f3b43, 64'hd24f2590c0bcee28,
		64'h33ea8f71bb6016d8, 64'hb5d2697595d0a01f, 64'h9bb30a32f00e2b4f,
		64'h4acea09317a429d1, 64'hc2b2435dfdd545c6, 64'hfda811a785572a42,
		64'he5f50676bf67137b
	};

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	wmh_pkg::in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	wmh_pkg::out_item_t out_data;
	logic      cfg_we;
	logic [0:0] cfg_index;
	logic [63:0] cfg_data;

	wide_multiply_hash_128_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [63:0] seed_lo, seed_hi;
	logic [63:0] lane [6];
	logic [63:0] carry;
	logic [7:0]  buf_b [96];
	int          buf_cnt;
	logic [63:0] msg_len;
	bit          absorbed;

	wmh_pkg::in_item_t  pending_items [$];
	wmh_pkg::out_item_t expected_hashes [$];
	int        fail_count;
	int        hold_cycles;
	int        in_gap;
	int        out_gap;
	bit        hold_req;
	bit        sender_paused;

	// stall state as seen at the last rising edge
	logic in_stall_q;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [127:0] mul128(input logic [63:0] a, input logic [63:0] b);
		return {64'd0, a} * {64'd0, b};
	endfunction

	function automatic logic [63:0] rd_word(input logic [7:0] v [96], input int off);
		logic [63:0] w;
		w = '0;
		for (int k = 7; k >= 0; k--)
			w = {w[55:0], v[(off + k + 96) % 96]};
		return w;
	endfunction

	task automatic start_msg();
		lane[0] = KC[0] ^ (seed_lo & MASK_I_C);
		lane[1] = KC[1] ^ (seed_hi & MASK_J_C);
		lane[2] = KC[2] ^ (seed_lo & MASK_K_C);
		lane[3] = KC[3] ^ (seed_hi & MASK_I_C);
		lane[4] = KC[4] ^ (seed_lo & MASK_J_C);
		lane[5] = KC[5] ^ (seed_hi & MASK_K_C);
		carry = KC[6];
		buf_cnt = 0;
		msg_len = '0;
		absorbed = 1'b0;
	endtask

	task automatic absorb();
		logic [63:0] lo [6];
		logic [63:0] hi [6];
		logic [127:0] p;
		int b;
		for (int r = 0; r < 6; r++) begin
			b = (r + 1) % 6;
			lane[r] ^= rd_word(buf_b, 16 * r);
			lane[b] ^= rd_word(buf_b, 16 * r + 8);
			p = mul128(lane[r], lane[b]);
			lo[r] = p[63:0];
			hi[r] = p[127:64];
			lane[r] = (r == 0 ? carry : lo[r - 1]) ^ hi[r];
		end
		carry = lo[5];
		absorbed = 1'b1;
	endtask

	function automatic wmh_pkg::out_item_t finish_hash();
		logic [7:0]  v [96];
		logic [63:0] s [6];
		logic [63:0] lo [6];
		logic [63:0] hi [6];
		logic [63:0] i, j, k;
		logic [127:0] p;
		int q, rot;
		wmh_pkg::out_item_t o;
		v = buf_b;
		s = lane;
		q = buf_cnt;
		rot = int'(msg_len[5:0]);
		if (!absorbed && q < 32) begin
			for (int x = q; x < 32; x++)
				v[x] = 8'h00;
			q = 32;
		end
		if (absorbed)
			s[0] ^= carry;
		for (int r = 0; r < 4; r++) begin
			lo[r] = '0;
			hi[r] = s[r + 1];
		end
		for (int r = 0; r < 4; r++) begin
			if (q <= 32 + 16 * r)
				break;
			s[r] ^= rd_word(v, 16 * r);
			s[r + 1] ^= rd_word(v, 16 * r + 8);
			p = mul128(s[r], s[r + 1]);
			lo[r] = p[63:0];
			hi[r] = p[127:64];
		end
		s[4] ^= rd_word(v, q - 32);
		s[5] ^= rd_word(v, q - 24);
		p = mul128(s[4], s[5]);
		lo[4] = p[63:0]; hi[4] = p[127:64];
		s[5] ^= rd_word(v, q - 16);
		s[0] ^= rd_word(v, q - 8);
		p = mul128(s[5], s[0]);
		lo[5] = p[63:0]; hi[5] = p[127:64];
		i = (s[0] - s[1]) ^ KC[7];
		j = (s[2] - s[3]) ^ KC[8];
		k = (s[4] - s[5]) ^ KC[9];
		if (rot != 0) begin
			i = (i << rot) | (i >> (64 - rot));
			j = (j >> rot) | (j << (64 - rot));
		end
		k = k - msg_len;
		i = i - (lo[3] ^ hi[3]) - (lo[4] ^ hi[4]);
		j = j - (lo[5] ^ hi[5]) - (lo[0] ^ hi[0]);
		k = k - (lo[1] ^ hi[1]) - (lo[2] ^ hi[2]);
		p = mul128(i, j); lo[0] = p[63:0]; hi[0] = p[127:64];
		p = mul128(j, k); lo[1] = p[63:0]; hi[1] = p[127:64];
		p = mul128(k, i); lo[2] = p[63:0]; hi[2] = p[127:64];
		i = lo[2] ^ hi[0];
		j = lo[0] ^ hi[1];
		k = lo[1] ^ hi[2];
		p = mul128(i, KC[10]); lo[3] = p[63:0]; hi[3] = p[127:64];
		p = mul128(j, KC[11]); lo[4] = p[63:0]; hi[4] = p[127:64];
		p = mul128(k, KC[12]); lo[5] = p[63:0]; hi[5] = p[127:64];
		o.hash_low  = lo[3] ^ hi[4] ^ lo[5];
		o.hash_high = hi[3] ^ lo[4] ^ hi[5];
		return o;
	endfunction

	// one accepted transaction through the predictor
	task automatic predict_word(input wmh_pkg::in_item_t it);
		int n;
		n = (it.byte_count > 4'd8) ? 8 : int'(it.byte_count);
		for (int b = 0; b < n; b++) begin
			if (buf_cnt >= 96) begin
				absorb();
				buf_cnt = 0;
			end
			buf_b[buf_cnt] = it.data_word[8 * b +: 8];
			buf_cnt++;
			msg_len++;
		end
		if (it.last) begin
			expected_hashes.push_back(finish_hash());
			start_msg();
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		fail_count++;
	endtask

	// driver: offers queued items, changes at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_gap > 0)
				in_gap--;
			if ((!in_valid || !in_stall_q) && !sender_paused && pending_items.size() > 0
					&& in_gap == 0 && ($urandom_range(0, 3) != 0)) begin
				in_data  <= pending_items.pop_front();
				in_valid <= 1'b1;
				in_gap = ($urandom_range(0, 29) == 0) ? $urandom_range(10, 60) : 0;
			end else if (in_valid && !in_stall_q) begin
				in_valid <= 1'b0;
			end
			if (out_gap > 0)
				out_gap--;
			else if ($urandom_range(0, 49) == 0)
				out_gap = $urandom_range(10, 60);
			out_stall <= (hold_req || out_gap > 0) ? 1'b1 :
				($urandom_range(0, 9) < 3) ? 1'b1 : 1'b0;
		end
	end

	// monitor: sample at the rising edge
	always @(posedge clk) begin
		in_stall_q <= in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_word(in_data);
			if (out_valid && !out_stall) begin
				if (expected_hashes.size() == 0) begin
					report("unexpected hash", out_data.hash_low, '0);
				end else begin
					wmh_pkg::out_item_t e;
					e = expected_hashes.pop_front();
					if (out_data.hash_low !== e.hash_low)
						report("hash_low", out_data.hash_low, e.hash_low);
					if (out_data.hash_high !== e.hash_high)
						report("hash_high", out_data.hash_high, e.hash_high);
				end
			end
		end
	end

	task automatic add_item(input logic [63:0] w, input int n, input bit lst);
		wmh_pkg::in_item_t it;
		it.data_word  = w;
		it.byte_count = 4'(n);
		it.last       = lst;
		pending_items.push_back(it);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// message of a given byte length, random split into words
	task automatic add_message(input int len);
		int left, n;
		left = len;
		while (left > 0) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 8;
			if (n > left)
				n = left;
			if ($urandom_range(0, 9) == 0 && n == 8)
				n = $urandom_range(9, 15);
			left -= (n > 8) ? 8 : n;
			add_item(rnd64(), n, 1'b0);
		end
		add_item(rnd64(), 0, 1'b1);
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_hashes.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_seed(input logic [0:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == wmh_pkg::REG_SEED_LOW)
			seed_lo = val;
		else
			seed_hi = val;
		if (buf_cnt == 0 && !absorbed)
			start_msg();
	endtask

	initial begin
		int lens [$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = wmh_pkg::REG_SEED_LOW;
		cfg_data = '0;
		hold_req = 1'b0;
		sender_paused = 1'b0;
		in_gap = 0;
		out_gap = 0;
		fail_count = 0;
		seed_lo = '0;
		seed_hi = '0;
		for (int x = 0; x < 96; x++)
			buf_b[x] = '0;
		start_msg();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty message, single bytes, extremes, block edges
		add_item(64'hffff_ffff_ffff_ffff, 0, 1'b1);
		add_item(64'hffff_ffff_ffff_ffff, 8, 1'b1);
		add_item(64'h0, 8, 1'b1);
		add_item(64'h1234_5678_9abc_def0, 15, 1'b1);
		add_item(64'hffff_ffff_ffff_ffff, 1, 1'b0);
		add_item(64'h0, 0, 1'b0);
		add_item(64'haaaa_5555_aaaa_5555, 7, 1'b1);
		for (int x = 0; x < 12; x++)
			add_item(rnd64(), 8, 1'b0);
		add_item(rnd64(), 0, 1'b1);
		drain();

		// seed sweep: extremes, then random
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_seed(wmh_pkg::REG_SEED_LOW, 64'hffff_ffff_ffff_ffff);
					write_seed(wmh_pkg::REG_SEED_HIGH, 64'hffff_ffff_ffff_ffff);
				end
				1: begin
					write_seed(wmh_pkg::REG_SEED_LOW, 64'h0);
					write_seed(wmh_pkg::REG_SEED_HIGH, 64'hffff_ffff_ffff_ffff);
				end
				default: begin
					write_seed(wmh_pkg::REG_SEED_LOW, rnd64());
					write_seed(wmh_pkg::REG_SEED_HIGH, rnd64());
				end
			endcase
			lens = {0, 1, 31, 32, 33, 95, 96, 97, 191, 192, 193};
			if (ph < 2)
				foreach (lens[x])
					add_message(lens[x]);
			for (int m = 0; m < 12; m++)
				add_message(($urandom_range(0, 4) == 0) ? $urandom_range(97, 300)
					: $urandom_range(0, 96));
			// mid-message seed write: takes effect on the next message
			if (ph == 3) begin
				drain();
				add_item(rnd64(), 5, 1'b0);
				while (pending_items.size() > 0 || in_valid)
					@(posedge clk);
				repeat (20) @(posedge clk);
				write_seed(wmh_pkg::REG_SEED_HIGH, rnd64());
				add_item(rnd64(), 3, 1'b1);
			end
			if (ph == 2) begin
				hold_req = 1'b1;
				hold_cycles = 0;
				while (hold_cycles < 1500) begin
					@(posedge clk);
					hold_cycles++;
				end
				hold_req = 1'b0;
			end
			if (ph == 4) begin
				while (pending_items.size() > 20)
					@(posedge clk);
				sender_paused = 1'b1;
				while (in_valid || expected_hashes.size() > 0)
					@(posedge clk);
				sender_paused = 1'b0;
			end
			drain();
		end

		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("testbench failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
src/wmh_pkg.sv
src/wmh_mem.sv
src/wmh_mul.sv
src/wmh_dp.sv
src/wmh_ctrl.sv
src/wide_multiply_hash_128_top.sv
bench/testbench.sv
